>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(name, ante, cons)

`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> rtl/rqvg_pkg.sv
package rqvg_pkg;

  localparam int DEF_COORD_BITS       = 16;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     ONE_Q14     = 16384;

  localparam int ANGLE_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = ANGLE_BITS - 2;
  localparam int SINE_BITS       = 15;
  localparam int TRIG_BITS       = 16;
  localparam int TEX_BITS        = 16;
  localparam int DIM_BITS        = 15;
  localparam int PIVOT_BITS      = 16;
  localparam int DELTA_BITS      = 18;
  localparam int PROD_BITS       = 33;
  localparam int SUM_BITS        = PROD_BITS + 1;
  localparam int FRAC_SHIFT      = 14;
  localparam int ROT_BITS        = SUM_BITS - FRAC_SHIFT;

  localparam int QUEUE_DEPTH = 2;

  localparam int PADDR_BITS = 5;
  localparam int PDATA_BITS = 32;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef enum logic [PADDR_BITS-3:0] {
    REG_TEX_LEFT    = 3'd0,
    REG_TEX_TOP     = 3'd1,
    REG_TEX_WIDTH   = 3'd2,
    REG_TEX_HEIGHT  = 3'd3,
    REG_QUAD_WIDTH  = 3'd4,
    REG_QUAD_HEIGHT = 3'd5,
    REG_PIVOT_X     = 3'd6,
    REG_PIVOT_Y     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [TEX_BITS-1:0]   tex_left;
    logic        [TEX_BITS-1:0]   tex_top;
    logic        [TEX_BITS-1:0]   tex_width;
    logic        [TEX_BITS-1:0]   tex_height;
    logic        [DIM_BITS-1:0]   quad_width;
    logic        [DIM_BITS-1:0]   quad_height;
    logic signed [PIVOT_BITS-1:0] pivot_x;
    logic signed [PIVOT_BITS-1:0] pivot_y;
  } cfg_regs_t;

endpackage

>>> rtl/rqvg_cfg.sv
module rqvg_cfg import rqvg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg_o
);

  cfg_regs_t cfg_q, cfg_d;
  cfg_reg_e  reg_sel;
  logic      wr_en;

  assign reg_sel = cfg_reg_e'(paddr[PADDR_BITS-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_TEX_LEFT:    cfg_d.tex_left    = pwdata[TEX_BITS-1:0];
        REG_TEX_TOP:     cfg_d.tex_top     = pwdata[TEX_BITS-1:0];
        REG_TEX_WIDTH:   cfg_d.tex_width   = pwdata[TEX_BITS-1:0];
        REG_TEX_HEIGHT:  cfg_d.tex_height  = pwdata[TEX_BITS-1:0];
        REG_QUAD_WIDTH:  cfg_d.quad_width  = pwdata[DIM_BITS-1:0];
        REG_QUAD_HEIGHT: cfg_d.quad_height = pwdata[DIM_BITS-1:0];
        REG_PIVOT_X:     cfg_d.pivot_x     = $signed(pwdata[PIVOT_BITS-1:0]);
        REG_PIVOT_Y:     cfg_d.pivot_y     = $signed(pwdata[PIVOT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TEX_LEFT:    prdata = PDATA_BITS'(cfg_q.tex_left);
      REG_TEX_TOP:     prdata = PDATA_BITS'(cfg_q.tex_top);
      REG_TEX_WIDTH:   prdata = PDATA_BITS'(cfg_q.tex_width);
      REG_TEX_HEIGHT:  prdata = PDATA_BITS'(cfg_q.tex_height);
      REG_QUAD_WIDTH:  prdata = PDATA_BITS'(cfg_q.quad_width);
      REG_QUAD_HEIGHT: prdata = PDATA_BITS'(cfg_q.quad_height);
      REG_PIVOT_X:     prdata = PDATA_BITS'(cfg_q.pivot_x);
      REG_PIVOT_Y:     prdata = PDATA_BITS'(cfg_q.pivot_y);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/rqvg_front.sv
module rqvg_front import rqvg_pkg::*; #(
  parameter int COORD_BITS       = DEF_COORD_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
  localparam int IDX_BITS        = $clog2(SINE_TABLE_DEPTH + 1),
  localparam int ENTRY_BITS      = 2 * COORD_BITS + 2 * IDX_BITS + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic        [ANGLE_BITS-1:0] turn_angle_i,
  output logic                         push_o,
  output logic        [ENTRY_BITS-1:0] entry_o,
  input  logic                         full_i
);

  localparam int PHASE_BITS = ANGLE_FRAC_BITS + IDX_BITS;

  logic                  valid_q;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [IDX_BITS-1:0]   sin_idx_q, cos_idx_q, sin_idx_d, cos_idx_d;
  logic                  sin_neg_q, cos_neg_q;
  logic [1:0]            quadrant;
  logic [PHASE_BITS-1:0] phase_prod;
  logic [IDX_BITS-1:0]   phase_rem, phase_mirror;
  logic                  accept;

  // quadrant is the top two angle bits, the remainder scales the rest
  assign quadrant     = turn_angle_i[ANGLE_BITS-1:ANGLE_FRAC_BITS];
  assign phase_prod   = PHASE_BITS'(turn_angle_i[ANGLE_FRAC_BITS-1:0])
                      * PHASE_BITS'(SINE_TABLE_DEPTH);
  assign phase_rem    = IDX_BITS'(phase_prod >> ANGLE_FRAC_BITS);
  assign phase_mirror = IDX_BITS'(SINE_TABLE_DEPTH) - phase_rem;
  assign sin_idx_d    = quadrant[0] ? phase_mirror : phase_rem;
  assign cos_idx_d    = quadrant[0] ? phase_rem : phase_mirror;

  assign push_o     = valid_q & ~full_i;
  assign in_stall_o = valid_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign entry_o    = {pos_x_q, pos_y_q, sin_idx_q, cos_idx_q, sin_neg_q, cos_neg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_x_q   <= pos_x_i;
      pos_y_q   <= pos_y_i;
      sin_idx_q <= sin_idx_d;
      cos_idx_q <= cos_idx_d;
      sin_neg_q <= quadrant[1];
      cos_neg_q <= quadrant[1] ^ quadrant[0];
    end
  end

endmodule

>>> rtl/rqvg_queue.sv
`include "assert_macros.svh"

module rqvg_queue import rqvg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_IMPL(a_no_overflow, push_i, !full_o || pop_i)
  `ASSERT_IMPL(a_no_underflow, pop_i, valid_o)
  `ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == CNT_BITS'($past(count_q) + 1))

endmodule

>>> rtl/rqvg_back.sv
`include "assert_macros.svh"

module rqvg_back import rqvg_pkg::*; #(
  parameter int COORD_BITS       = DEF_COORD_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
  localparam int IDX_BITS        = $clog2(SINE_TABLE_DEPTH + 1),
  localparam int ENTRY_BITS      = 2 * COORD_BITS + 2 * IDX_BITS + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_regs_t                    cfg_i,
  input  logic                         q_valid_i,
  input  logic        [ENTRY_BITS-1:0] q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] vert_x_o,
  output logic signed [COORD_BITS-1:0] vert_y_o,
  output logic        [TEX_BITS-1:0]   tex_u_o,
  output logic        [TEX_BITS-1:0]   tex_v_o,
  output logic        [1:0]            corner_index_o,
  output logic                         last_corner_o
);

  localparam int VSUM_BITS = ((COORD_BITS > ROT_BITS) ? COORD_BITS : ROT_BITS) + 1;
  localparam logic signed [VSUM_BITS-1:0] VERT_MAX =
    VSUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [VSUM_BITS-1:0] VERT_MIN = -VERT_MAX - VSUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1 << (FRAC_SHIFT - 1));

  typedef logic [SINE_BITS-1:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

  // quarter-wave sine in Q1.14, taylor series in Q30 rounded to Q14
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t tab;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = term;
      term = ((term * x2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum  = sum - term;
      if (sum < 0) begin
        sum = 0;
      end
      tab[k] = SINE_BITS'((sum + 64'sd32768) >>> 16);
    end
    tab[0]                = '0;
    tab[SINE_TABLE_DEPTH] = SINE_BITS'(ONE_Q14);
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // queue entry
  logic signed [COORD_BITS-1:0] e_pos_x, e_pos_y;
  logic        [IDX_BITS-1:0]   e_sin_idx, e_cos_idx;
  logic                         e_sin_neg, e_cos_neg;
  logic signed [TRIG_BITS-1:0]  sin_mag, cos_mag;

  assign {e_pos_x, e_pos_y, e_sin_idx, e_cos_idx, e_sin_neg, e_cos_neg} = q_data_i;
  assign sin_mag = TRIG_BITS'(SINE_ROM[e_sin_idx]);
  assign cos_mag = TRIG_BITS'(SINE_ROM[e_cos_idx]);

  // stage 0: corner sequencer
  logic                         s0_valid_q;
  corner_e                      s0_corner_q;
  logic signed [TRIG_BITS-1:0]  s0_sin_q, s0_cos_q;
  logic signed [COORD_BITS-1:0] s0_pos_x_q, s0_pos_y_q;

  // stage 1: products
  logic                         s1_valid_q;
  corner_e                      s1_corner_q;
  logic signed [PROD_BITS-1:0]  s1_xc_q, s1_ys_q, s1_xs_q, s1_yc_q;
  logic signed [COORD_BITS-1:0] s1_pos_x_q, s1_pos_y_q;

  // stage 2: rounded rotation
  logic                         s2_valid_q;
  corner_e                      s2_corner_q;
  logic signed [ROT_BITS-1:0]   s2_rot_x_q, s2_rot_y_q;
  logic signed [COORD_BITS-1:0] s2_pos_x_q, s2_pos_y_q;

  // stage 3: output word
  logic                         s3_valid_q;
  corner_e                      s3_corner_q;
  logic signed [COORD_BITS-1:0] s3_vert_x_q, s3_vert_y_q;
  logic        [TEX_BITS-1:0]   s3_tex_u_q, s3_tex_v_q;

  logic en1, en2, en3;
  logic s0_issue, s0_done;

  assign en3      = ~s3_valid_q | ~out_stall_i;
  assign en2      = ~s2_valid_q | en3;
  assign en1      = ~s1_valid_q | en2;
  assign s0_issue = s0_valid_q & en1;
  assign s0_done  = s0_issue & (s0_corner_q == CORNER_BL);
  assign q_pop_o  = q_valid_i & (~s0_valid_q | s0_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s0_corner_q <= CORNER_TL;
    end else if (q_pop_o) begin
      s0_valid_q  <= 1'b1;
      s0_corner_q <= CORNER_TL;
    end else if (s0_done) begin
      s0_valid_q  <= 1'b0;
    end else if (s0_issue) begin
      s0_corner_q <= corner_e'(s0_corner_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s0_sin_q   <= e_sin_neg ? -sin_mag : sin_mag;
      s0_cos_q   <= e_cos_neg ? -cos_mag : cos_mag;
      s0_pos_x_q <= e_pos_x;
      s0_pos_y_q <= e_pos_y;
    end
  end

  // corner offsets from the pivot
  logic                        s0_right, s0_bottom;
  logic signed [DELTA_BITS-1:0] dx, dy;
  logic signed [PROD_BITS-1:0]  dx_ext, dy_ext, sin_ext, cos_ext;

  assign s0_right  = (s0_corner_q == CORNER_TR) || (s0_corner_q == CORNER_BR);
  assign s0_bottom = (s0_corner_q == CORNER_BR) || (s0_corner_q == CORNER_BL);
  assign dx = (s0_right ? DELTA_BITS'(cfg_i.quad_width) : '0) - DELTA_BITS'(cfg_i.pivot_x);
  assign dy = (s0_bottom ? DELTA_BITS'(cfg_i.quad_height) : '0) - DELTA_BITS'(cfg_i.pivot_y);
  assign dx_ext  = PROD_BITS'(dx);
  assign dy_ext  = PROD_BITS'(dy);
  assign sin_ext = PROD_BITS'(s0_sin_q);
  assign cos_ext = PROD_BITS'(s0_cos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_corner_q <= CORNER_TL;
    end else if (en1) begin
      s1_valid_q  <= s0_valid_q;
      s1_corner_q <= s0_corner_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_xc_q    <= dx_ext * cos_ext;
      s1_ys_q    <= dy_ext * sin_ext;
      s1_xs_q    <= dx_ext * sin_ext;
      s1_yc_q    <= dy_ext * cos_ext;
      s1_pos_x_q <= s0_pos_x_q;
      s1_pos_y_q <= s0_pos_y_q;
    end
  end

  // round half up to a signed integer, Q20.0
  logic signed [SUM_BITS-1:0] rot_x_sum, rot_y_sum;

  assign rot_x_sum = SUM_BITS'(s1_xc_q) - SUM_BITS'(s1_ys_q) + ROUND_HALF;
  assign rot_y_sum = SUM_BITS'(s1_xs_q) + SUM_BITS'(s1_yc_q) + ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s2_corner_q <= CORNER_TL;
    end else if (en2) begin
      s2_valid_q  <= s1_valid_q;
      s2_corner_q <= s1_corner_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_rot_x_q <= ROT_BITS'(rot_x_sum >>> FRAC_SHIFT);
      s2_rot_y_q <= ROT_BITS'(rot_y_sum >>> FRAC_SHIFT);
      s2_pos_x_q <= s1_pos_x_q;
      s2_pos_y_q <= s1_pos_y_q;
    end
  end

  // add position, clamp, texture corner
  logic signed [VSUM_BITS-1:0] vx_sum, vy_sum, vx_sat, vy_sat;
  logic                        s2_right, s2_bottom;
  logic        [TEX_BITS:0]    u_sum, v_sum;

  assign vx_sum = VSUM_BITS'(s2_pos_x_q) + VSUM_BITS'(s2_rot_x_q);
  assign vy_sum = VSUM_BITS'(s2_pos_y_q) + VSUM_BITS'(s2_rot_y_q);
  assign vx_sat = (vx_sum > VERT_MAX) ? VERT_MAX : ((vx_sum < VERT_MIN) ? VERT_MIN : vx_sum);
  assign vy_sat = (vy_sum > VERT_MAX) ? VERT_MAX : ((vy_sum < VERT_MIN) ? VERT_MIN : vy_sum);

  assign s2_right  = (s2_corner_q == CORNER_TR) || (s2_corner_q == CORNER_BR);
  assign s2_bottom = (s2_corner_q == CORNER_BR) || (s2_corner_q == CORNER_BL);
  assign u_sum = {1'b0, cfg_i.tex_left} + (s2_right ? {1'b0, cfg_i.tex_width} : '0);
  assign v_sum = {1'b0, cfg_i.tex_top} + (s2_bottom ? {1'b0, cfg_i.tex_height} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s3_corner_q <= CORNER_TL;
    end else if (en3) begin
      s3_valid_q  <= s2_valid_q;
      s3_corner_q <= s2_corner_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_vert_x_q <= COORD_BITS'(vx_sat);
      s3_vert_y_q <= COORD_BITS'(vy_sat);
      s3_tex_u_q  <= u_sum[TEX_BITS] ? '1 : u_sum[TEX_BITS-1:0];
      s3_tex_v_q  <= v_sum[TEX_BITS] ? '1 : v_sum[TEX_BITS-1:0];
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign vert_x_o       = s3_vert_x_q;
  assign vert_y_o       = s3_vert_y_q;
  assign tex_u_o        = s3_tex_u_q;
  assign tex_v_o        = s3_tex_v_q;
  assign corner_index_o = s3_corner_q;
  assign last_corner_o  = (s3_corner_q == CORNER_BL);

  `ASSERT_NEXT(a_corner_step, s0_issue && (s0_corner_q != CORNER_BL),
               s0_valid_q && (s0_corner_q == corner_e'($past(s0_corner_q) + 2'd1)))
  `ASSERT_IMPL(a_corner_chain_front, s0_valid_q && s1_valid_q,
               s0_corner_q == corner_e'(s1_corner_q + 2'd1))
  `ASSERT_IMPL(a_corner_chain_back, s2_valid_q && s3_valid_q,
               s2_corner_q == corner_e'(s3_corner_q + 2'd1))

endmodule

>>> rtl/rotated_quad_vertex_generator.sv
// throughput: one vertex word per cycle while out_stall_i is low, set by the corner
//   sequencer that issues the four corners through one product stage; later requests
//   wait in the front register and queue until the last corner issues
// reset: config registers clear to zero and all stages empty; the sine table is
//   a constant, so requests are taken from the first cycle after reset
module rotated_quad_vertex_generator import rqvg_pkg::*; #(
  parameter int COORD_BITS       = DEF_COORD_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic        [PADDR_BITS-1:0] paddr,
  input  logic        [PDATA_BITS-1:0] pwdata,
  output logic        [PDATA_BITS-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic        [ANGLE_BITS-1:0] turn_angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] vert_x_o,
  output logic signed [COORD_BITS-1:0] vert_y_o,
  output logic        [TEX_BITS-1:0]   tex_u_o,
  output logic        [TEX_BITS-1:0]   tex_v_o,
  output logic        [1:0]            corner_index_o,
  output logic                         last_corner_o
);

  localparam int IDX_BITS   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ENTRY_BITS = 2 * COORD_BITS + 2 * IDX_BITS + 2;

  cfg_regs_t             cfg;
  logic                  push, full, pop, q_valid;
  logic [ENTRY_BITS-1:0] push_entry, head_entry;

  rqvg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rqvg_front #(
    .COORD_BITS       (COORD_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .turn_angle_i (turn_angle_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full)
  );

  rqvg_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_entry)
  );

  rqvg_back #(
    .COORD_BITS       (COORD_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_data_i       (head_entry),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vert_x_o       (vert_x_o),
    .vert_y_o       (vert_y_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .corner_index_o (corner_index_o),
    .last_corner_o  (last_corner_o)
  );

endmodule
